FILE: hdl/neighbour_label_mode_finder_macros.svh
// ----------------------------------------------------------------------------
// neighbour_label_mode_finder_macros.svh
// Assertion macros shared by the label mode finder modules.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOUR_LABEL_MODE_FINDER_MACROS_SVH
`define NEIGHBOUR_LABEL_MODE_FINDER_MACROS_SVH

`ifndef SYNTH

`define NLMF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("label mode finder: check failed");

`define NLMF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("label mode finder: check failed");

`else

`define NLMF_ASSERT(lbl, prop)

`define NLMF_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

FILE: hdl/nlmf_pkg.sv
// ----------------------------------------------------------------------------
// nlmf_pkg
// Types and constants of the neighbour label mode finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nlmf_pkg;

  localparam int FIELD_BITS = 16;
  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [FIELD_BITS-1:0] neighbour_label;
    logic [FIELD_BITS-1:0] own_label;
    logic                  is_last;
    logic                  is_empty;
  } in_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] winning_label;
    logic [COUNT_BITS-1:0] winning_count;
    logic                  label_changed;
    logic                  table_overflow;
  } out_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic inc_idx;
    logic clr_idx;
    logic add_new;
    logic bump;
    logic set_ovf;
    logic clr_best;
    logic take_best;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic new_empty;
    logic item_last;
    logic at_used;
    logic full;
    logic match;
    logic greater;
  } ctrl_sts_t;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SRCH_RD  = 6'b000010,
    S_SRCH_CMP = 6'b000100,
    S_MAX_RD   = 6'b001000,
    S_MAX_CMP  = 6'b010000,
    S_SPARE    = 6'b100000
  } state_t;

endpackage

FILE: hdl/nlmf_ram.sv
// ----------------------------------------------------------------------------
// nlmf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/nlmf_ctrl.sv
// ----------------------------------------------------------------------------
// nlmf_ctrl
// Sequencer for the table search, insert and final count scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "neighbour_label_mode_finder_macros.svh"

module nlmf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  nlmf_pkg::ctrl_sts_t   sts_i,
  output nlmf_pkg::ctrl_cmd_t   cmd_o
);

  nlmf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nlmf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    unique case (state_r)
      nlmf_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (sts_i.new_empty) begin
            cmd_o.clr_best = 1'b1;
            state_nxt      = nlmf_pkg::S_MAX_RD;
          end else begin
            state_nxt = nlmf_pkg::S_SRCH_RD;
          end
        end
      end
      nlmf_pkg::S_SRCH_RD: begin
        if (sts_i.at_used) begin
          if (sts_i.full) begin
            cmd_o.set_ovf = 1'b1;
          end else begin
            cmd_o.add_new = 1'b1;
          end
          if (sts_i.item_last) begin
            cmd_o.clr_idx  = 1'b1;
            cmd_o.clr_best = 1'b1;
            state_nxt      = nlmf_pkg::S_MAX_RD;
          end else begin
            state_nxt = nlmf_pkg::S_IDLE;
          end
        end else begin
          cmd_o.rd  = 1'b1;
          state_nxt = nlmf_pkg::S_SRCH_CMP;
        end
      end
      nlmf_pkg::S_SRCH_CMP: begin
        if (sts_i.match) begin
          cmd_o.bump = 1'b1;
          if (sts_i.item_last) begin
            cmd_o.clr_idx  = 1'b1;
            cmd_o.clr_best = 1'b1;
            state_nxt      = nlmf_pkg::S_MAX_RD;
          end else begin
            state_nxt = nlmf_pkg::S_IDLE;
          end
        end else begin
          cmd_o.inc_idx = 1'b1;
          state_nxt     = nlmf_pkg::S_SRCH_RD;
        end
      end
      nlmf_pkg::S_MAX_RD: begin
        if (sts_i.at_used) begin
          cmd_o.emit = 1'b1;
          state_nxt  = nlmf_pkg::S_IDLE;
        end else begin
          cmd_o.rd  = 1'b1;
          state_nxt = nlmf_pkg::S_MAX_CMP;
        end
      end
      nlmf_pkg::S_MAX_CMP: begin
        cmd_o.take_best = sts_i.greater;
        cmd_o.inc_idx   = 1'b1;
        state_nxt       = nlmf_pkg::S_MAX_RD;
      end
      default: begin
        state_nxt = nlmf_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != nlmf_pkg::S_IDLE);

  `NLMF_ASSERT(a_cmp_after_rd, (state_r == nlmf_pkg::S_SRCH_CMP) |-> ($past(state_r) == nlmf_pkg::S_SRCH_RD))
  `NLMF_ASSERT(a_emit_idle, cmd_o.emit |=> !busy)
  `NLMF_ASSERT(a_state_onehot, $onehot(state_r))

endmodule

FILE: hdl/nlmf_datapath.sv
// ----------------------------------------------------------------------------
// nlmf_datapath
// Label table memories, search index, best-entry registers and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "neighbour_label_mode_finder_macros.svh"

module nlmf_datapath #(
  parameter int TABLE_ENTRIES = 64,
  parameter int LABEL_BITS    = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nlmf_pkg::in_t         in_item,
  input  nlmf_pkg::ctrl_cmd_t   cmd_i,
  output nlmf_pkg::ctrl_sts_t   sts_o,
  output logic                  out_valid,
  output nlmf_pkg::out_t        out_item
);

  localparam int AW     = $clog2(TABLE_ENTRIES);
  localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CW     = nlmf_pkg::COUNT_BITS;

  nlmf_pkg::in_t       item_r, item_nxt;
  logic [USED_W-1:0]   idx_r, idx_nxt;
  logic [USED_W-1:0]   used_r, used_nxt;
  logic                ovf_r, ovf_nxt;
  logic [LABEL_BITS-1:0] best_label_r, best_label_nxt;
  logic [CW-1:0]       best_count_r, best_count_nxt;
  logic                out_valid_r, out_valid_nxt;
  nlmf_pkg::out_t      out_item_r, out_item_nxt;

  logic [LABEL_BITS-1:0] lab;
  logic [LABEL_BITS-1:0] own;
  logic [LABEL_BITS-1:0] rd_label;
  logic [CW-1:0]         rd_count;
  logic                  lab_we;
  logic                  cnt_we;
  logic [AW-1:0]         waddr;
  logic [CW-1:0]         cnt_wdata;

  assign lab = LABEL_BITS'(item_r.neighbour_label);
  assign own = LABEL_BITS'(item_r.own_label);

  assign lab_we    = cmd_i.add_new;
  assign cnt_we    = cmd_i.add_new | cmd_i.bump;
  assign waddr     = cmd_i.add_new ? used_r[AW-1:0] : idx_r[AW-1:0];
  assign cnt_wdata = cmd_i.add_new ? CW'(1) :
                     ((rd_count == nlmf_pkg::COUNT_MAX) ? rd_count : rd_count + CW'(1));

  nlmf_ram #(
    .WIDTH (LABEL_BITS),
    .DEPTH (TABLE_ENTRIES)
  ) u_label_ram (
    .clk   (clk),
    .we    (lab_we),
    .waddr (waddr),
    .wdata (lab),
    .re    (cmd_i.rd),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd_label)
  );

  nlmf_ram #(
    .WIDTH (CW),
    .DEPTH (TABLE_ENTRIES)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (waddr),
    .wdata (cnt_wdata),
    .re    (cmd_i.rd),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd_count)
  );

  always_comb begin
    sts_o.new_empty = in_item.is_empty;
    sts_o.item_last = item_r.is_last;
    sts_o.at_used   = (idx_r == used_r);
    sts_o.full      = (used_r == USED_W'(TABLE_ENTRIES));
    sts_o.match     = (rd_label == lab);
    sts_o.greater   = (rd_count > best_count_r);
  end

  always_comb begin
    item_nxt       = cmd_i.load ? in_item : item_r;
    idx_nxt        = idx_r;
    used_nxt       = used_r;
    ovf_nxt        = ovf_r;
    best_label_nxt = best_label_r;
    best_count_nxt = best_count_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = out_item_r;

    if (cmd_i.load || cmd_i.clr_idx) begin
      idx_nxt = '0;
    end else if (cmd_i.inc_idx) begin
      idx_nxt = idx_r + USED_W'(1);
    end
    if (cmd_i.add_new) begin
      used_nxt = used_r + USED_W'(1);
    end
    if (cmd_i.set_ovf) begin
      ovf_nxt = 1'b1;
    end
    if (cmd_i.clr_best) begin
      best_label_nxt = '0;
      best_count_nxt = '0;
    end else if (cmd_i.take_best) begin
      best_label_nxt = rd_label;
      best_count_nxt = rd_count;
    end
    if (cmd_i.emit) begin
      out_valid_nxt                = 1'b1;
      out_item_nxt.winning_label   = nlmf_pkg::FIELD_BITS'(best_label_r);
      out_item_nxt.winning_count   = best_count_r;
      out_item_nxt.label_changed   = (best_label_r != own);
      out_item_nxt.table_overflow  = ovf_r;
      used_nxt                     = '0;
      ovf_nxt                      = 1'b0;
      idx_nxt                      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      used_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      used_r      <= used_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    best_label_r <= best_label_nxt;
    best_count_r <= best_count_nxt;
    out_item_r   <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `NLMF_ASSERT(a_used_range, used_r <= USED_W'(TABLE_ENTRIES))
  `NLMF_ASSERT(a_idx_range, idx_r <= used_r)
  `NLMF_ASSERT(a_emit_clears, cmd_i.emit |=> (used_r == '0 && !ovf_r && out_valid))
  `NLMF_ASSERT_ALWAYS(a_single_pulse, (rst_n && out_valid_r) |=> !out_valid_r)

endmodule

FILE: hdl/neighbour_label_mode_finder.sv
// ----------------------------------------------------------------------------
// neighbour_label_mode_finder
// Plurality vote over one node's neighbour labels.
// ----------------------------------------------------------------------------
// An item transfers at a rising edge with start high and busy low. Each
// neighbour item walks the label table, reading one entry in S_SRCH_RD and
// comparing it in S_SRCH_CMP: busy stays high until the label is found and
// its count bumped, or until every entry in use is passed and the label is
// added as a new entry (or, if the table is full, the overflow flag is set).
// An item that ends the node then scans the table for the largest count,
// which keeps busy high through every entry in use, the item's own included;
// an isolated node item gives only that scan. out_valid flags the result on
// out_item for exactly one cycle, the first cycle that busy is low again; the
// receiver must take it then, since nothing holds it back. There is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module neighbour_label_mode_finder #(
  parameter int TABLE_ENTRIES = 64,
  parameter int LABEL_BITS    = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  nlmf_pkg::in_t  in_item,
  output logic           out_valid,
  output nlmf_pkg::out_t out_item
);

  nlmf_pkg::ctrl_cmd_t cmd;
  nlmf_pkg::ctrl_sts_t sts;

  nlmf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  nlmf_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .LABEL_BITS    (LABEL_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
